### rtl/uv_pkg.sv
`default_nettype none
package uv_pkg;

	// Default queue depths
	localparam int unsigned CLS_DEPTH = 2;
	localparam int unsigned RES_DEPTH = 2;

	// Longest legacy lead: 1111110x opens five continuation bytes
	localparam logic [2:0] MAX_CONT = 3'd5;

	// Byte classes handed from the front to the back
	typedef enum logic [2:0] {
		CLS_ASCII,
		CLS_CONT,
		CLS_LEAD,
		CLS_BAD,
		CLS_END
	} uv_kind_t;

	typedef struct packed {
		uv_kind_t   kind;
		logic [2:0] len;    // continuation bytes opened by a lead
	} uv_cls_t;

	localparam int unsigned CLS_W = $bits(uv_cls_t);

	// Verdict codes
	typedef enum logic [1:0] {
		VERDICT_INVALID = 2'd0,
		VERDICT_ASCII   = 2'd1,
		VERDICT_UTF8    = 2'd2
	} uv_verdict_t;

	localparam int unsigned VERDICT_W = $bits(uv_verdict_t);

endpackage
`default_nettype wire

### rtl/uv_fifo.sv
`default_nettype none
module uv_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/uv_front.sv
`default_nettype none
module uv_front
	import uv_pkg::*;
(
	input  wire logic       push,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_string,
	input  wire logic       cls_full,
	output logic            full,
	output logic            cls_push,
	output uv_cls_t         cls_data
);

	assign full     = cls_full;
	assign cls_push = push && !cls_full;

	// Class decode: an end item first, else count leading ones of the byte
	always_comb begin
		cls_data.kind = CLS_ASCII;
		cls_data.len  = '0;
		if (end_of_string) begin
			cls_data.kind = CLS_END;
		end else if (!data_byte[7]) begin
			cls_data.kind = CLS_ASCII;
		end else if (!data_byte[6]) begin
			cls_data.kind = CLS_CONT;
		end else if (!data_byte[5]) begin
			cls_data.kind = CLS_LEAD;
			cls_data.len  = 3'd1;
		end else if (!data_byte[4]) begin
			cls_data.kind = CLS_LEAD;
			cls_data.len  = 3'd2;
		end else if (!data_byte[3]) begin
			cls_data.kind = CLS_LEAD;
			cls_data.len  = 3'd3;
		end else if (!data_byte[2]) begin
			cls_data.kind = CLS_LEAD;
			cls_data.len  = 3'd4;
		end else if (!data_byte[1]) begin
			cls_data.kind = CLS_LEAD;
			cls_data.len  = MAX_CONT;
		end else begin
			cls_data.kind = CLS_BAD;    // 0xFE or 0xFF
		end
	end

endmodule
`default_nettype wire

### rtl/uv_back.sv
`default_nettype none
module uv_back
	import uv_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cls_empty,
	input  uv_cls_t   cls_data,
	output logic      cls_pop,
	input  wire logic res_full,
	output logic      res_push,
	output uv_verdict_t res_verdict
);

	logic [2:0] pend_q;
	logic       multi_q;
	logic       ascii_q;
	logic       err_q;
	logic       is_end;

	assign is_end   = (cls_data.kind == CLS_END);
	// An end transfer needs room in the result queue
	assign cls_pop  = !cls_empty && (!is_end || !res_full);
	assign res_push = cls_pop && is_end;

	// Verdict from the current string state
	always_comb begin
		if (err_q) begin
			res_verdict = VERDICT_INVALID;
		end else if (multi_q) begin
			res_verdict = VERDICT_UTF8;
		end else if (ascii_q) begin
			res_verdict = VERDICT_ASCII;
		end else begin
			res_verdict = VERDICT_INVALID;
		end
	end

	// String state update, one class per cycle on cls_pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			multi_q <= 1'b0;
			ascii_q <= 1'b1;
			err_q   <= 1'b0;
		end else if (cls_pop) begin
			if (is_end) begin
				pend_q  <= '0;
				multi_q <= 1'b0;
				ascii_q <= 1'b1;
				err_q   <= 1'b0;
			end else if (!err_q) begin
				if (pend_q != '0) begin
					if (cls_data.kind == CLS_CONT) begin
						pend_q <= pend_q - 1'b1;
						if (pend_q == 3'd1) begin
							multi_q <= 1'b1;
						end
					end else begin
						err_q <= 1'b1;
					end
				end else begin
					case (cls_data.kind)
						CLS_ASCII: ;
						CLS_CONT: err_q <= 1'b1;
						CLS_LEAD: begin
							ascii_q <= 1'b0;
							pend_q  <= cls_data.len;
						end
						CLS_BAD: begin
							ascii_q <= 1'b0;
							err_q   <= 1'b1;
						end
						default: ;
					endcase
				end
			end
		end
	end

	// Pending count never exceeds the longest lead
	assert property (@(posedge clk) disable iff (!arst_n) pend_q <= MAX_CONT)
		else $error("pending continuation count out of range");

	// A verdict returns the string state to its reset values
	assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (pend_q == '0) && !multi_q && ascii_q && !err_q)
		else $error("string state not cleared after verdict");

	// Error stays until the end of the string
	assert property (@(posedge clk) disable iff (!arst_n)
		(err_q && !res_push) |=> err_q)
		else $error("error flag dropped inside a string");

	// An open or completed sequence rules out plain ASCII
	assert property (@(posedge clk) disable iff (!arst_n)
		(multi_q || pend_q != '0) |-> !ascii_q)
		else $error("multibyte state with ascii flag set");

endmodule
`default_nettype wire

### rtl/utf8_validator.sv
`default_nettype none
// An item accepted at the input is classified into the class queue; the back pops
// it from there and, for an end item, writes the verdict into the result queue,
// where the consumer pops it. Throughput: one byte or end item per cycle while
// neither queue is full, set by the single state update in the back.
// Reset (arst_n low) empties both queues and clears string state.
module utf8_validator
	import uv_pkg::*;
#(
	parameter int unsigned CLS_QDEPTH = CLS_DEPTH,
	parameter int unsigned RES_QDEPTH = RES_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_string,
	output logic            empty,
	input  wire logic       pop,
	output logic [1:0]      verdict
);

	uv_cls_t     fr_cls;
	uv_cls_t     bk_cls;
	logic [CLS_W-1:0] bk_cls_bits;
	logic        fr_push;
	logic        cls_full, cls_empty, cls_pop;
	logic        res_full, res_push;
	uv_verdict_t res_verdict;

	uv_front u_front (
		.push          (push),
		.data_byte     (data_byte),
		.end_of_string (end_of_string),
		.cls_full      (cls_full),
		.full          (full),
		.cls_push      (fr_push),
		.cls_data      (fr_cls)
	);

	// Class queue between front and back
	uv_fifo #(
		.WIDTH (CLS_W),
		.DEPTH (CLS_QDEPTH)
	) u_cls_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fr_push),
		.wr_data (fr_cls),
		.full    (cls_full),
		.pop     (cls_pop),
		.rd_data (bk_cls_bits),
		.empty   (cls_empty)
	);

	assign bk_cls = uv_cls_t'(bk_cls_bits);

	uv_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cls_empty   (cls_empty),
		.cls_data    (bk_cls),
		.cls_pop     (cls_pop),
		.res_full    (res_full),
		.res_push    (res_push),
		.res_verdict (res_verdict)
	);

	// Result queue toward the consumer
	uv_fifo #(
		.WIDTH (VERDICT_W),
		.DEPTH (RES_QDEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_verdict),
		.full    (res_full),
		.pop     (pop),
		.rd_data (verdict),
		.empty   (empty)
	);

endmodule
`default_nettype wire

### tb/sv/utf8_validator_tb.sv
`default_nettype none
module utf8_validator_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import uv_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] data_byte = 8'h00;
	logic       end_of_string = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [1:0] verdict;

	utf8_validator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.end_of_string(end_of_string),
		.empty        (empty),
		.pop          (pop),
		.verdict      (verdict)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop in case the handshake hangs
	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

	// Idle rates in percent, changed per phase
	int unsigned send_idle_pct = 16;
	int unsigned recv_idle_pct = 64;

	int unsigned mismatches = 0;
	int unsigned sent_items = 0;

	// Verdicts owed by the block, oldest first
	uv_verdict_t verdict_q[$];

	// Per-string classification state
	logic [2:0] cont_left;
	logic       multibyte_done;
	logic       ascii_only;
	logic       seq_error;

	task automatic clear_string();
		cont_left      = 3'd0;
		multibyte_done = 1'b0;
		ascii_only     = 1'b1;
		seq_error      = 1'b0;
	endtask

	// Advance the classifier by one string byte
	task automatic scan_byte(input logic [7:0] b);
		if (seq_error) begin
			return;
		end
		if (cont_left != 3'd0) begin
			if (b[7:6] != 2'b10) begin
				seq_error = 1'b1;
			end else begin
				cont_left = cont_left - 3'd1;
				if (cont_left == 3'd0) begin
					multibyte_done = 1'b1;
				end
			end
			return;
		end
		if (!b[7]) begin
			return;
		end
		if (!b[6]) begin
			seq_error = 1'b1;   // stray continuation
			return;
		end
		ascii_only = 1'b0;
		if (!b[5])      cont_left = 3'd1;
		else if (!b[4]) cont_left = 3'd2;
		else if (!b[3]) cont_left = 3'd3;
		else if (!b[2]) cont_left = 3'd4;
		else if (!b[1]) cont_left = 3'd5;
		else            seq_error = 1'b1;   // FE / FF lead
	endtask

	// Verdict for the string so far, then back to the empty string
	task automatic close_string(output uv_verdict_t v);
		if (seq_error)           v = VERDICT_INVALID;
		else if (multibyte_done) v = VERDICT_UTF8;
		else if (ascii_only)     v = VERDICT_ASCII;
		else                     v = VERDICT_INVALID;
		clear_string();
	endtask

	// One transfer on the input side; the expectation is recorded at the accepting edge
	task automatic send_item(input logic [7:0] b, input logic eos,
			input bit typed, input uv_verdict_t typed_v);
		uv_verdict_t v;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push          <= 1'b1;
		data_byte     <= b;
		end_of_string <= eos;
		do begin
			@(posedge clk);
		end while (full);
		sent_items++;
		if (eos) begin
			close_string(v);
			verdict_q.push_back(typed ? typed_v : v);
		end else begin
			scan_byte(b);
		end
	endtask

	// Random byte of a sequence: 0 gives ASCII, 1..5 a lead opening that many continuations
	function automatic logic [7:0] lead_byte(input int unsigned n);
		case (n)
			1: begin
				return {3'b110, 5'($urandom)};
			end
			2: begin
				return {4'b1110, 4'($urandom)};
			end
			3: begin
				return {5'b11110, 3'($urandom)};
			end
			4: begin
				return {6'b111110, 2'($urandom)};
			end
			5: begin
				return {7'b1111110, 1'($urandom)};
			end
			default: begin
				return 8'($urandom_range(1, 127));
			end
		endcase
	endfunction

	function automatic logic [7:0] cont_byte();
		return {2'b10, 6'($urandom)};
	endfunction

	// Build one string, mostly well formed, and send it with its end item
	task automatic send_string();
		logic [7:0]  bytes_q[$];
		int unsigned nchars;
		int unsigned n;
		int unsigned mode;
		int unsigned pos;
		nchars = $urandom_range(0, 6);
		for (int i = 0; i < nchars; i++) begin
			n = ($urandom_range(9) < 4) ? 0 : $urandom_range(1, 5);
			bytes_q.push_back(lead_byte(n));
			for (int k = 0; k < n; k++) begin
				bytes_q.push_back(cont_byte());
			end
		end
		mode = $urandom_range(0, 15);
		case (mode)
			// pure noise
			0: begin
				bytes_q.delete();
				repeat ($urandom_range(1, 6)) bytes_q.push_back(8'($urandom_range(1, 255)));
			end
			// sequence cut short by the end
			1, 2: begin
				n = $urandom_range(1, 5);
				bytes_q.push_back(lead_byte(n));
				repeat ($urandom_range(0, n - 1)) bytes_q.push_back(cont_byte());
			end
			// stray continuation or FE/FF lead somewhere in the string
			3: begin
				pos = $urandom_range(0, bytes_q.size());
				bytes_q.insert(pos, $urandom_range(1) ? cont_byte() : {7'h7F, 1'($urandom)});
			end
			// one byte overwritten
			4: begin
				if (bytes_q.size() != 0) begin
					pos = $urandom_range(0, bytes_q.size() - 1);
					bytes_q[pos] = 8'($urandom_range(1, 255));
				end
			end
			default: begin
			end
		endcase
		foreach (bytes_q[i]) begin
			send_item(bytes_q[i], 1'b0, 1'b0, VERDICT_INVALID);
		end
		send_item(8'($urandom_range(1, 255)), 1'b1, 1'b0, VERDICT_INVALID);
	endtask

	// Directed rows; want is only meaningful on end rows
	typedef struct packed {
		logic [7:0]  data;
		logic        eos;
		uv_verdict_t want;
	} dir_row_t;

	localparam int N_DIR = 27;
	dir_row_t dir_rows [0:N_DIR-1] = '{
		// empty string, data ignored on the end item
		'{8'hFF, 1'b1, VERDICT_ASCII},
		// ASCII extremes
		'{8'h01, 1'b0, VERDICT_INVALID},
		'{8'h7F, 1'b0, VERDICT_INVALID},
		'{8'h00, 1'b1, VERDICT_ASCII},
		// longest legacy form: FC lead and five continuations
		'{8'hFC, 1'b0, VERDICT_INVALID},
		'{8'h80, 1'b0, VERDICT_INVALID},
		'{8'hBF, 1'b0, VERDICT_INVALID},
		'{8'h80, 1'b0, VERDICT_INVALID},
		'{8'h80, 1'b0, VERDICT_INVALID},
		'{8'hBF, 1'b0, VERDICT_INVALID},
		'{8'h80, 1'b1, VERDICT_UTF8},
		// completed pair, then a five-byte lead cut short
		'{8'hC3, 1'b0, VERDICT_INVALID},
		'{8'hA9, 1'b0, VERDICT_INVALID},
		'{8'hF8, 1'b0, VERDICT_INVALID},
		'{8'h01, 1'b1, VERDICT_UTF8},
		// bad continuation; later valid pair does not clear the error
		'{8'hE2, 1'b0, VERDICT_INVALID},
		'{8'h41, 1'b0, VERDICT_INVALID},
		'{8'hC3, 1'b0, VERDICT_INVALID},
		'{8'hA9, 1'b0, VERDICT_INVALID},
		'{8'h55, 1'b1, VERDICT_INVALID},
		// stray continuation
		'{8'h80, 1'b0, VERDICT_INVALID},
		'{8'hAA, 1'b1, VERDICT_INVALID},
		// FE and FF leads
		'{8'hFE, 1'b0, VERDICT_INVALID},
		'{8'hFF, 1'b0, VERDICT_INVALID},
		'{8'h7F, 1'b1, VERDICT_INVALID},
		// lead cut short with nothing completed before it
		'{8'hF0, 1'b0, VERDICT_INVALID},
		'{8'hFF, 1'b1, VERDICT_INVALID}
	};

	// Receiver side: random pop
	always @(posedge clk) begin
		if (arst_n) begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin : check_verdicts
		uv_verdict_t want;
		if (arst_n && pop && !empty) begin
			if (verdict_q.size() == 0) begin
				if (mismatches < 10) begin
					$display("%0t: unexpected verdict %0d", $realtime, verdict);
				end
				mismatches++;
			end else begin
				want = verdict_q.pop_front();
				if (verdict !== want) begin
					if (mismatches < 10) begin
						$display("%0t: verdict expected %0d got %0d",
							$realtime, want, verdict);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin
		int unsigned drain_cycles;
		clear_string();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase 1: sender idles a little, receiver a lot
		send_idle_pct = 16;
		recv_idle_pct = 64;
		for (int i = 0; i < N_DIR; i++) begin
			send_item(dir_rows[i].data, dir_rows[i].eos, dir_rows[i].eos, dir_rows[i].want);
		end
		while (sent_items < 400) send_string();

		// Phase 2: the other way round
		send_idle_pct = 64;
		recv_idle_pct = 16;
		while (sent_items < 800) send_string();

		// Phase 3: full rate on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (sent_items < 1200) send_string();
		push <= 1'b0;

		// Drain
		drain_cycles = 0;
		while (verdict_q.size() != 0 && drain_cycles < 10000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (10) @(posedge clk);

		if (mismatches == 0 && verdict_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

### files.f
rtl/uv_pkg.sv
rtl/uv_fifo.sv
rtl/uv_front.sv
rtl/uv_back.sv
rtl/utf8_validator.sv
tb/sv/utf8_validator_tb.sv
